// File: rtl/kst_pkg.sv
// Shared types and codes for the keyed sighting table.
package kst_pkg;

	typedef enum logic [1:0] {
		ST_UPDATED  = 2'd0,
		ST_INSERTED = 2'd1,
		ST_DROPPED  = 2'd2,
		ST_CLEARED  = 2'd3
	} status_t;

	typedef enum logic {
		OP_REPORT = 1'b0,
		OP_CLEAR  = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_MISS
	} state_t;

	localparam logic [15:0] HIT_MAX = 16'hFFFF;

	// One table entry as it sits in the entry memory.
	typedef struct packed {
		logic [47:0] key;
		logic [15:0] hits;
		logic        special;
		logic        tag_mark;
		logic [7:0]  strength;
		logic [31:0] first_seen;
		logic [31:0] last_seen;
	} entry_t;

endpackage

// File: rtl/keyed_sighting_table.sv
// Top level of the keyed sighting table: sequencer, key compare and entry update.
//
// Usage: one input channel (in_valid/in_ready) carries report or clear
// transactions; one output channel (out_valid/out_ready) returns exactly one
// result per input transaction, in order.
// A clear transaction is finished in the cycle it is accepted; its result is
// valid on the next cycle.
// A report scans the valid entries one per cycle through the single read port
// of the entry memory, with one compare unit. A miss scans every used entry,
// then inserts or drops; a hit ends the scan at the matching entry and updates
// it; with an empty table the scan is skipped and the report goes to insert.
// The block takes a new transaction only when no search is running and the
// result register is empty or is being emptied in that same cycle, so a
// stalled receiver holds off the input side.
// Reset empties the table by zeroing the used, special and tagged counts;
// entry contents are not cleared and are only used below the used count.
module keyed_sighting_table #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               opcode,
	input  logic [47:0]        device_address,
	input  logic signed [7:0]  signal_strength,
	input  logic               special_class,
	input  logic               position_tagged,
	input  logic [31:0]        time_ms,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [5:0]         entry_index,
	output logic [15:0]        entry_hits,
	output logic [31:0]        entry_first_seen,
	output logic [6:0]         entries_in_use,
	output logic [6:0]         special_total,
	output logic [6:0]         tagged_total
);
	import kst_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
	localparam logic [CW-1:0] ONE_C   = CW'(1);

	state_t state_q, state_d;

	logic [CW-1:0] used_q, special_q, tagged_q;
	logic [CW-1:0] used_d, special_d, tagged_d;
	logic [CW-1:0] rd_idx_q, cmp_idx_q;

	logic [47:0] addr_q;
	logic [7:0]  strength_q;
	logic        cls_q, tag_q;
	logic [31:0] now_q;

	logic        out_valid_q;
	status_t     res_status_q, res_status_d;
	logic [AW-1:0] res_idx_q, res_idx_d;
	logic [15:0] res_hits_q, res_hits_d;
	logic [31:0] res_first_q, res_first_d;
	logic        res_load;

	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	entry_t        ram_wdata, ram_rdata;

	logic in_fire, out_fire, key_hit, last_entry;

	kst_entry_ram #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid_q && out_ready;

	// Entry zero is read in the accept cycle; the scan then reads one ahead.
	assign ram_raddr  = (state_q == S_IDLE) ? '0 : rd_idx_q[AW-1:0];
	assign key_hit    = (ram_rdata.key == addr_q);
	assign last_entry = (cmp_idx_q == used_q - ONE_C);

	always_comb begin
		state_d      = state_q;
		used_d       = used_q;
		special_d    = special_q;
		tagged_d     = tagged_q;
		ram_we       = 1'b0;
		ram_waddr    = cmp_idx_q[AW-1:0];
		ram_wdata    = ram_rdata;
		res_load     = 1'b0;
		res_status_d = ST_DROPPED;
		res_idx_d    = '0;
		res_hits_d   = '0;
		res_first_d  = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					if (opcode == OP_CLEAR) begin
						used_d       = '0;
						special_d    = '0;
						tagged_d     = '0;
						res_load     = 1'b1;
						res_status_d = ST_CLEARED;
					end else if (used_q == '0) begin
						state_d = S_MISS;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (key_hit) begin
					ram_we = 1'b1;
					ram_wdata.hits = (ram_rdata.hits == HIT_MAX) ? HIT_MAX
						: ram_rdata.hits + 16'd1;
					ram_wdata.last_seen = now_q;
					ram_wdata.strength  = strength_q;
					ram_wdata.special   = cls_q;
					ram_wdata.tag_mark  = ram_rdata.tag_mark | tag_q;
					if (ram_rdata.special != cls_q) begin
						special_d = cls_q ? special_q + ONE_C : special_q - ONE_C;
					end
					if (tag_q && !ram_rdata.tag_mark) begin
						tagged_d = tagged_q + ONE_C;
					end
					res_load     = 1'b1;
					res_status_d = ST_UPDATED;
					res_idx_d    = cmp_idx_q[AW-1:0];
					res_hits_d   = ram_wdata.hits;
					res_first_d  = ram_rdata.first_seen;
					state_d      = S_IDLE;
				end else if (last_entry) begin
					state_d = S_MISS;
				end
			end
			S_MISS: begin
				res_load = 1'b1;
				state_d  = S_IDLE;
				if (used_q >= DEPTH_C) begin
					res_status_d = ST_DROPPED;
				end else begin
					ram_we               = 1'b1;
					ram_waddr            = used_q[AW-1:0];
					ram_wdata.key        = addr_q;
					ram_wdata.hits       = 16'd1;
					ram_wdata.special    = cls_q;
					ram_wdata.tag_mark   = tag_q;
					ram_wdata.strength   = strength_q;
					ram_wdata.first_seen = now_q;
					ram_wdata.last_seen  = now_q;
					used_d               = used_q + ONE_C;
					special_d            = special_q + CW'(cls_q);
					tagged_d             = tagged_q + CW'(tag_q);
					res_status_d         = ST_INSERTED;
					res_idx_d            = used_q[AW-1:0];
					res_hits_d           = 16'd1;
					res_first_d          = now_q;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			special_q   <= '0;
			tagged_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			used_q    <= used_d;
			special_q <= special_d;
			tagged_q  <= tagged_d;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			addr_q     <= device_address;
			strength_q <= signal_strength;
			cls_q      <= special_class;
			tag_q      <= position_tagged;
			now_q      <= time_ms;
			rd_idx_q   <= ONE_C;
			cmp_idx_q  <= '0;
		end else if (state_q == S_SCAN) begin
			rd_idx_q  <= rd_idx_q + ONE_C;
			cmp_idx_q <= rd_idx_q;
		end
		if (res_load) begin
			res_status_q <= res_status_d;
			res_idx_q    <= res_idx_d;
			res_hits_q   <= res_hits_d;
			res_first_q  <= res_first_d;
		end
	end

	// The counts only change when an item completes, so they can be shown live.
	assign out_valid        = out_valid_q;
	assign status           = res_status_q;
	assign entry_index      = 6'(res_idx_q);
	assign entry_hits       = res_hits_q;
	assign entry_first_seen = res_first_q;
	assign entries_in_use   = 7'(used_q);
	assign special_total    = 7'(special_q);
	assign tagged_total     = 7'(tagged_q);

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= DEPTH_C)
		else $error("used count exceeds table depth");

	a_marks_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(special_q <= used_q) && (tagged_q <= used_q))
		else $error("special or tagged total exceeds used count");

	a_busy_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !out_valid_q)
		else $error("result pending while a search is running");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && opcode == OP_CLEAR) |=> (used_q == '0) && out_valid_q
			&& (res_status_q == ST_CLEARED))
		else $error("clear transaction did not empty the table");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (cmp_idx_q < used_q))
		else $error("scan ran past the used entries");

endmodule

// File: rtl/kst_entry_ram.sv
// Entry memory: one write port and one registered read port.
module kst_entry_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  kst_pkg::entry_t     wdata,
	input  logic [AW-1:0]       raddr,
	output kst_pkg::entry_t     rdata
);
	import kst_pkg::*;

	entry_t mem_q [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
